// ===== rtl/core/jers_pkg.sv =====
`timescale 1ns / 1ps

package jers_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int ROWS_LIMIT = 4096;
    localparam int BUF_DEPTH  = MAX_COLS + 2;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int COL_W      = 11;
    localparam int ROW_W      = 13;
    localparam int CFG_W      = 13;
    localparam int PIX_W      = 16;
    // compare widths hold cols + 2 and rows + 2 without overflow
    localparam int CW         = ((ADDR_W > COL_W) ? ADDR_W : COL_W) + 2;
    localparam int RW         = ((ROW_W > $clog2(ROWS_LIMIT + 1)) ? ROW_W
                                 : $clog2(ROWS_LIMIT + 1)) + 2;
    // sum of four pixels minus one pixel
    localparam int SUM_W      = PIX_W + 3;

    localparam logic CFG_FRAME_COLS = 1'b0;
    localparam logic CFG_FRAME_ROWS = 1'b1;

    localparam logic [COL_W-1:0] COLS_RESET = COL_W'(640);
    localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(480);

    typedef struct packed {
        logic signed [PIX_W-1:0] old_value;
        logic signed [PIX_W-1:0] edge_value;
        logic                    frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [PIX_W-1:0] new_value;
        logic                    last_pixel;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] addr_right;
        logic              emit;
        logic              last;
    } t_pos;

endpackage

// ===== rtl/core/jers_ram.sv =====
`timescale 1ns / 1ps

module jers_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1026
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/jers_pos.sv =====
`timescale 1ns / 1ps

module jers_pos
    import jers_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_adv,
    input  logic             i_frame_start,
    output t_pos             o_pos
);

    logic [COL_W-1:0] r_cols, n_cols;
    logic [ROW_W-1:0] r_rows, n_rows;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [CW-1:0]    cols_eff, x, cols_raw;
    logic [RW-1:0]    rows_eff, y, rows_raw;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             wrap_col, wrap_row;

    // out-of-range sizes: zero counts as one, large values clip
    always_comb begin
        cols_raw = CW'(r_cols);
        rows_raw = RW'(r_rows);
        if (cols_raw == '0) begin
            cols_eff = CW'(1);
        end else if (cols_raw > CW'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = cols_raw;
        end
        if (rows_raw == '0) begin
            rows_eff = RW'(1);
        end else if (rows_raw > RW'(ROWS_LIMIT)) begin
            rows_eff = RW'(ROWS_LIMIT);
        end else begin
            rows_eff = rows_raw;
        end
    end

    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;
        x = CW'(cur_col);
        if (x > CW'(BUF_DEPTH - 1)) begin
            x = CW'(BUF_DEPTH - 1);
        end
        y = RW'(cur_row);

        o_pos.addr       = x[ADDR_W-1:0];
        o_pos.addr_right = (x < CW'(BUF_DEPTH - 1)) ? ADDR_W'(x + CW'(1)) : '0;
        o_pos.emit       = (y >= RW'(2)) && (y <= rows_eff + RW'(1))
                           && (x >= CW'(1)) && (x <= cols_eff);
        o_pos.last       = (y == rows_eff + RW'(1)) && (x == cols_eff);

        wrap_col = (CW'(cur_col) + CW'(1)) >= (cols_eff + CW'(2));
        wrap_row = (RW'(cur_row) + RW'(1)) >= (rows_eff + RW'(2));
    end

    always_comb begin
        n_cols = r_cols;
        n_rows = r_rows;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_COLS: n_cols = i_cfg_data[COL_W-1:0];
                CFG_FRAME_ROWS: n_rows = i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (wrap_col) begin
                n_col = '0;
                n_row = wrap_row ? '0 : cur_row + ROW_W'(1);
            end else begin
                n_col = cur_col + COL_W'(1);
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_cols <= n_cols;
            r_rows <= n_rows;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

endmodule

// ===== rtl/core/jers_stencil.sv =====
`timescale 1ns / 1ps

module jers_stencil
    import jers_pkg::*;
(
    input  logic signed [PIX_W-1:0] i_up,
    input  logic signed [PIX_W-1:0] i_down,
    input  logic signed [PIX_W-1:0] i_left,
    input  logic signed [PIX_W-1:0] i_right,
    input  logic signed [PIX_W-1:0] i_edge,
    output logic signed [PIX_W-1:0] o_new
);

    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(32768);

    logic signed [SUM_W-1:0] sum, q;

    function automatic logic signed [SUM_W-1:0] sx(input logic signed [PIX_W-1:0] v);
        sx = {{(SUM_W - PIX_W){v[PIX_W-1]}}, v};
    endfunction

    // arithmetic shift floors, so +2 gives round to nearest, ties up
    always_comb begin
        sum = sx(i_up) + sx(i_down) + sx(i_left) + sx(i_right) - sx(i_edge)
              + SUM_W'(2);
        q = sum >>> 2;
        if (q > Q_MAX) begin
            o_new = 16'sh7fff;
        end else if (q < Q_MIN) begin
            o_new = 16'sh8000;
        end else begin
            o_new = q[PIX_W-1:0];
        end
    end

endmodule

// ===== rtl/core/jacobi_edge_reconstruct_sweep.sv =====
`timescale 1ns / 1ps
// one pixel word per cycle in while the output is not stalled; a result word is
// shown on the output after the pixel below it is accepted, through the stage A
// and output registers; rate is set by one read and one write per cycle on each
// line-buffer ram. reset: counters to zero, frame_cols 640, frame_rows 480,
// pipeline empty; line buffers keep their contents and need no clearing pass

module jacobi_edge_reconstruct_sweep
    import jers_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  t_in_word         i_in_word,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_word        o_out_word,
    input  logic             i_out_stall
);

    localparam int WIDE_W = 3 * PIX_W;

    t_pos pos;
    logic accept, a_go, out_free;

    logic                    r_a_valid;
    logic [ADDR_W-1:0]       r_a_addr;
    logic signed [PIX_W-1:0] r_a_old, r_a_edge;
    logic                    r_a_emit, r_a_last;
    logic                    r_fw_hit, r_fn_hit;
    logic [WIDE_W-1:0]       r_fw_data;
    logic [PIX_W-1:0]        r_fn_data;
    logic signed [PIX_W-1:0] r_left;
    logic                    r_o_valid;
    t_out_word               r_o_word;

    logic [WIDE_W-1:0]       wide_q, wide_rd, wide_wd;
    logic [PIX_W-1:0]        narrow_rd, right;
    logic signed [PIX_W-1:0] up, center, edge_mid, new_value;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_o_valid || !i_out_stall;
    assign a_go     = r_a_valid && (!r_a_emit || out_free);
    assign o_in_stall = r_a_valid && !a_go;

    jers_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_adv         (accept),
        .i_frame_start (i_in_word.frame_start),
        .o_pos         (pos)
    );

    // word per column: {row y-2, row y-1, edge of row y-1}
    jers_ram #(.WIDTH(WIDE_W), .DEPTH(BUF_DEPTH)) u_ram_cross (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_addr),
        .i_wdata (wide_wd),
        .i_re    (accept),
        .i_raddr (pos.addr),
        .o_rdata (wide_rd)
    );

    // copy of the middle row, read one column ahead for the right neighbor
    jers_ram #(.WIDTH(PIX_W), .DEPTH(BUF_DEPTH)) u_ram_right (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_addr),
        .i_wdata (r_a_old),
        .i_re    (accept),
        .i_raddr (pos.addr_right),
        .o_rdata (narrow_rd)
    );

    always_comb begin
        wide_q   = r_fw_hit ? r_fw_data : wide_rd;
        right    = r_fn_hit ? r_fn_data : narrow_rd;
        up       = wide_q[3*PIX_W-1:2*PIX_W];
        center   = wide_q[2*PIX_W-1:PIX_W];
        edge_mid = wide_q[PIX_W-1:0];
        wide_wd  = {center, r_a_old, r_a_edge};
    end

    jers_stencil u_stencil (
        .i_up    (up),
        .i_down  (r_a_old),
        .i_left  (r_left),
        .i_right (right),
        .i_edge  (edge_mid),
        .o_new   (new_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
            r_fw_hit  <= 1'b0;
            r_fn_hit  <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                // the write of the word leaving now lands at the same edge
                r_fw_hit  <= a_go && (r_a_addr == pos.addr);
                r_fn_hit  <= a_go && (r_a_addr == pos.addr_right);
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
            if (a_go) begin
                r_left <= center;
            end
            if (a_go && r_a_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_addr  <= pos.addr;
            r_a_old   <= i_in_word.old_value;
            r_a_edge  <= i_in_word.edge_value;
            r_a_emit  <= pos.emit;
            r_a_last  <= pos.last;
            r_fw_data <= wide_wd;
            r_fn_data <= r_a_old;
        end
        if (a_go && r_a_emit) begin
            r_o_word.new_value  <= new_value;
            r_o_word.last_pixel <= r_a_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(a_go && r_a_emit))
        else $error("output word without a finished stencil");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_out_stall) |-> !(a_go && r_a_emit))
        else $error("stalled output word overwritten");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> !o_in_stall)
        else $error("input stalled with empty stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_go) |=> (r_a_valid && $stable(r_a_addr)))
        else $error("held stage lost its word");

endmodule

// ===== tb/jacobi_edge_reconstruct_sweep_tb.sv =====
`timescale 1ns / 1ps

module jacobi_edge_reconstruct_sweep_tb;
    import jers_pkg::*;

    localparam int STALL_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 4;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int PIX_MAX          = 32767;
    localparam int PIX_MIN          = -32768;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic             i_cfg_index = CFG_FRAME_COLS;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    t_in_word         i_in_word   = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_word        o_out_word;
    logic             i_out_stall = 1'b0;

    jacobi_edge_reconstruct_sweep i_dut (.*);

    // stencil predictor state
    logic signed [PIX_W-1:0] above_line  [BUF_DEPTH];
    logic signed [PIX_W-1:0] middle_line [BUF_DEPTH];
    logic signed [PIX_W-1:0] edge_line   [BUF_DEPTH];
    logic signed [PIX_W-1:0] prev_center;
    int unsigned             cols_reg;
    int unsigned             rows_reg;
    int unsigned             col_pos;
    int unsigned             row_pos;

    t_in_word  pixel_q[$];
    t_out_word expected_pixels[$];
    t_out_word want;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int quiet_cycles  = 0;
    int queued_items  = 0;
    bit word_taken    = 1'b0;

    int phase_send[4]  = '{0, 68, 0, 17};
    int phase_stall[4] = '{0, 0, 68, 17};

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // one pixel through the four-neighbor cross; queues the new interior value if any
    function automatic void sweep_pixel(t_in_word w);
        int unsigned             cols;
        int unsigned             rows;
        int unsigned             x;
        int unsigned             y;
        logic signed [PIX_W-1:0] center;
        logic signed [PIX_W-1:0] left;
        int                      up;
        int                      down;
        int                      lf;
        int                      rt;
        int                      ed;
        int                      q;
        t_out_word               res;
        cols = clamp_size(cols_reg, MAX_COLS);
        rows = clamp_size(rows_reg, ROWS_LIMIT);
        if (w.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = (col_pos >= BUF_DEPTH) ? BUF_DEPTH - 1 : col_pos;
        y = row_pos;
        center = middle_line[x];
        left = prev_center;
        if (y >= 2 && y <= rows + 1 && x >= 1 && x <= cols) begin
            up   = $signed(above_line[x]);
            down = $signed(w.old_value);
            lf   = $signed(left);
            rt   = $signed(middle_line[x + 1]);
            ed   = $signed(edge_line[x]);
            // floor of (sum + 2) / 4 rounds to nearest, ties upward
            q = (up + down + lf + rt - ed + 2) >>> 2;
            if (q > PIX_MAX) q = PIX_MAX;
            else if (q < PIX_MIN) q = PIX_MIN;
            res.new_value = q[PIX_W-1:0];
            res.last_pixel = (y == rows + 1 && x == cols);
            expected_pixels.push_back(res);
        end
        above_line[x] = center;
        middle_line[x] = w.old_value;
        edge_line[x] = w.edge_value;
        prev_center = center;
        // counters left beyond a shrunk size wrap at once
        if (col_pos + 1 >= cols + 2) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows + 2) ? 0 : ((row_pos + 1) & 'h1fff);
        end else begin
            col_pos = (col_pos + 1) & 'h7ff;
        end
    endfunction

    task automatic flag_error(string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            col_pos = 0;
            row_pos = 0;
            prev_center = '0;
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_COLS) cols_reg = i_cfg_data[COL_W-1:0];
                else rows_reg = i_cfg_data[ROW_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                sweep_pixel(i_in_word);
                word_taken = 1'b1;
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (expected_pixels.size() == 0) begin
                    flag_error($sformatf("unexpected word new_value=%0d last_pixel=%0b",
                                         o_out_word.new_value, o_out_word.last_pixel));
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_word.new_value !== want.new_value)
                        flag_error($sformatf("new_value expected %0d got %0d",
                                             want.new_value, o_out_word.new_value));
                    if (o_out_word.last_pixel !== want.last_pixel)
                        flag_error($sformatf("last_pixel expected %0b got %0b",
                                             want.last_pixel, o_out_word.last_pixel));
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (!i_in_valid || word_taken) begin
            word_taken = 1'b0;
            if (i_rst_n && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word <= pixel_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: begin
                return 16'h7fff;
            end
            1: begin
                return 16'h8000;
            end
            default: begin
                return PIX_W'($urandom);
            end
        endcase
    endfunction

    // keep > 0 cuts the frame short; noise_pct scatters stray frame starts
    task automatic queue_frame(int unsigned cols, int unsigned rows, bit start,
                               int noise_pct, int keep);
        int       total;
        t_in_word w;
        total = (clamp_size(cols, MAX_COLS) + 2) * (clamp_size(rows, ROWS_LIMIT) + 2);
        if (keep > 0 && keep < total) total = keep;
        for (int i = 0; i < total; i++) begin
            w.old_value = rand_pixel();
            w.edge_value = rand_pixel();
            w.frame_start = (i == 0) ? start : ($urandom_range(99) < noise_pct);
            pixel_q.push_back(w);
        end
        queued_items += total;
    endtask

    task automatic queue_flat(int n, logic [PIX_W-1:0] old_v, logic [PIX_W-1:0] edge_v,
                              bit start);
        t_in_word w;
        for (int i = 0; i < n; i++) begin
            w.old_value = old_v;
            w.edge_value = edge_v;
            w.frame_start = (i == 0) && start;
            pixel_q.push_back(w);
        end
    endtask

    task automatic wait_drain();
        while (pixel_q.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        // a halo word may still be in flight with nothing expected from it
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_sizes(int unsigned cols, int unsigned rows);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FRAME_COLS;
        i_cfg_data <= CFG_W'(cols);
        @(negedge i_clk);
        i_cfg_index <= CFG_FRAME_ROWS;
        i_cfg_data <= CFG_W'(rows);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned cols;
        int unsigned rows;
        int          goal;
        int          frames;
        int          kind;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one padded row and a bit at the reset width of 640, then narrow the
        // frame so row 1 ends early and row 2 is the last interior row
        queue_frame(640, 480, 1'b1, 0, 642 + 4);
        write_sizes(2, 1);
        queue_frame(2, 1, 1'b0, 0, 5);

        // saturation both ways; second frame wraps with no frame start
        write_sizes(1, 1);
        queue_flat(9, 16'h7fff, 16'h8000, 1'b1);
        queue_flat(9, 16'h8000, 16'h7fff, 1'b0);
        // zero sizes count as one
        write_sizes(0, 0);
        queue_frame(0, 0, 1'b1, 0, 0);

        // stop inside row 4, then shrink so both counters sit beyond the new size
        write_sizes(6, 6);
        queue_frame(6, 6, 1'b1, 0, 4 * 8 + 6);
        write_sizes(2, 2);
        repeat (3) queue_frame(2, 2, 1'b0, 0, 0);

        // oversize registers clamp to the widest row and the tallest frame
        write_sizes(2047, 1);
        queue_frame(2047, 1, 1'b1, 0, 40);
        write_sizes(1, 8191);
        queue_frame(1, 8191, 1'b1, 0, 8 * 3);

        foreach (phase_send[p]) begin
            send_idle_pct = phase_send[p];
            stall_pct = phase_stall[p];
            goal = queued_items + RANDOM_PER_PHASE;
            while (queued_items < goal) begin
                kind = $urandom_range(99);
                cols = (kind < 10) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                rows = $urandom_range(6, 1);
                if (kind >= 95) cols = 0;
                if ($urandom_range(19) == 0) rows = 0;
                write_sizes(cols, rows);
                // first frame after a size change always opens with a frame start
                queue_frame(cols, rows, 1'b1, ($urandom_range(3) == 0) ? 5 : 0, 0);
                frames = $urandom_range(4, 1);
                for (int f = 1; f < frames; f++) begin
                    kind = $urandom_range(99);
                    if (kind < 65) queue_frame(cols, rows, 1'b1, 0, 0);
                    else if (kind < 80) queue_frame(cols, rows, 1'b0, 0, 0);
                    else if (kind < 90) queue_frame(cols, rows, 1'b1, 8, 0);
                    else queue_frame(cols, rows, 1'b1, 0, $urandom_range(30, 1));
                end
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== jacobi_edge_reconstruct_sweep.f =====
rtl/core/jers_pkg.sv
rtl/core/jers_ram.sv
rtl/core/jers_pos.sv
rtl/core/jers_stencil.sv
rtl/core/jacobi_edge_reconstruct_sweep.sv
tb/jacobi_edge_reconstruct_sweep_tb.sv
